FILE: sv/pps_pkg.sv
// Package: shared types and constants of the PPM stream parser.
package pps_pkg;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_PIXEL  = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [2:0] ERR_MAGIC   = 3'd0;
  localparam logic [2:0] ERR_EARLY   = 3'd1;
  localparam logic [2:0] ERR_LONG    = 3'd2;
  localparam logic [2:0] ERR_NONNUM  = 3'd3;
  localparam logic [2:0] ERR_MAXV    = 3'd4;
  localparam logic [2:0] ERR_SAMPLE  = 3'd5;
  localparam logic [2:0] ERR_DIM     = 3'd6;

  localparam int TOKEN_BITS = 28;

  typedef enum logic [9:0] {
    PH_MAG0   = 10'b0000000001,
    PH_MAG1   = 10'b0000000010,
    PH_MAG2   = 10'b0000000100,
    PH_WIDTH  = 10'b0000001000,
    PH_HEIGHT = 10'b0000010000,
    PH_MAXV   = 10'b0000100000,
    PH_TEXT   = 10'b0001000000,
    PH_RAW    = 10'b0010000000,
    PH_DONE   = 10'b0100000000,
    PH_ERROR  = 10'b1000000000
  } phase_t;

  typedef enum logic [3:0] {
    CT_IDLE  = 4'b0001,
    CT_DIV   = 4'b0010,
    CT_OUT   = 4'b0100,
    CT_HOLD  = 4'b1000
  } ctl_state_t;

  // Command from controller to datapath.
  typedef struct packed {
    logic start;      // latch a sample for scaling
    logic emit;       // store a scaled sample; last channel fills output
  } dp_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic need_div;   // the accepted byte produced a sample
    logic direct;     // the accepted byte produced a non-pixel result
    logic div_done;
    logic out_full;
  } dp_stat_t;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == 8'h20) || (b == 8'h09) || (b == 8'h0D) || (b == 8'h0A);
  endfunction

  function automatic logic is_nl(input logic [7:0] b);
    return (b == 8'h0D) || (b == 8'h0A);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

endpackage

FILE: sv/pps_if.sv
// Interfaces: byte input channel and result output channel.
interface pps_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       end_of_file;
  modport source (output valid, output byte_in, output end_of_file, input ready);
  modport sink (input valid, input byte_in, input end_of_file, output ready);
endinterface

interface pps_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [15:0] image_width;
  logic [15:0] image_height;
  logic        is_binary;
  logic [2:0]  error_code;
  logic        last_pixel;
  modport source (output valid, output kind, output red, output green, output blue,
                  output image_width, output image_height, output is_binary,
                  output error_code, output last_pixel, input ready);
  modport sink (input valid, input kind, input red, input green, input blue,
                input image_width, input image_height, input is_binary,
                input error_code, input last_pixel, output ready);
endinterface

FILE: sv/pps_ctrl.sv
// Controller: sequences accept, sample scaling and result delivery.
module pps_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  pps_pkg::dp_stat_t stat,
  output pps_pkg::dp_cmd_t  cmd,
  output logic              accept
);
  import pps_pkg::*;

  ctl_state_t state, state_next;

  always_comb begin
    in_ready   = (state == CT_IDLE) && !stat.out_full;
    accept     = in_valid && in_ready;
    cmd.start  = accept && stat.need_div;
    cmd.emit   = (state == CT_OUT) && !stat.out_full;
    state_next = state;
    unique case (state)
      CT_IDLE: if (cmd.start) state_next = CT_DIV;
      CT_DIV:  if (stat.div_done) state_next = CT_OUT;
      CT_OUT:  if (!stat.out_full) state_next = CT_IDLE;
      CT_HOLD: state_next = CT_IDLE;
      default: state_next = CT_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= CT_IDLE;
    else state <= state_next;
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != CT_IDLE) |-> !accept) else $error("accept while busy");
  a_div_follows: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> (state == CT_DIV)) else $error("scaling not started");
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !stat.out_full) else $error("emit into full register");
  a_direct_no_div: assert property (@(posedge clk) disable iff (rst)
    (accept && stat.direct) |-> !cmd.start) else $error("direct result with scaling");
`endif
endmodule

FILE: sv/pps_datapath.sv
// Datapath: header parsing, token build, sample scaling and output register.
module pps_datapath #(
  parameter int MAX_TOKEN_LEN = 1024,
  parameter int DIM_BITS      = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        byte_in,
  input  logic              end_of_file,
  input  pps_pkg::dp_cmd_t  cmd,
  output pps_pkg::dp_stat_t stat,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [1:0]        kind,
  output logic [7:0]        red,
  output logic [7:0]        green,
  output logic [7:0]        blue,
  output logic [15:0]       image_width,
  output logic [15:0]       image_height,
  output logic              is_binary,
  output logic [2:0]        error_code,
  output logic              last_pixel
);
  import pps_pkg::*;

  localparam int LEN_BITS = $clog2(MAX_TOKEN_LEN + 1);
  localparam logic [TOKEN_BITS-1:0] DIM_MAX = TOKEN_BITS'((33'd1 << DIM_BITS) - 33'd1);
  localparam logic [TOKEN_BITS-1:0] TOKEN_SAT =
    (DIM_MAX + TOKEN_BITS'(1) > TOKEN_BITS'(65536)) ? DIM_MAX + TOKEN_BITS'(1)
                                                    : TOKEN_BITS'(65536);
  localparam logic [LEN_BITS-1:0] LEN_LIMIT = LEN_BITS'(MAX_TOKEN_LEN - 1);

  phase_t                phase;
  logic                  binary_format;
  logic [TOKEN_BITS-1:0] token_value;
  logic [LEN_BITS-1:0]   token_length;
  logic                  at_line_start, cmt_active;
  logic [DIM_BITS-1:0]   width_reg, height_reg, column_count, row_count;
  logic [15:0]           max_sample;
  logic [1:0]            channel_index;
  logic [7:0]            held_red, held_green, high_byte;
  logic                  byte_phase;

  // Next-state values computed from the accepted byte.
  phase_t                phase_next;
  logic                  binary_next, als_next, inc_next, bp_next;
  logic [TOKEN_BITS-1:0] tv_next;
  logic [LEN_BITS-1:0]   tl_next;
  logic [DIM_BITS-1:0]   w_next, h_next;
  logic [15:0]           max_next, hb_next;
  logic                  ev_sample, ev_direct, ev_eof_pend;
  logic [15:0]           sample_v;
  logic [1:0]            d_kind;
  logic [2:0]            d_err;
  logic                  d_last;
  logic [TOKEN_BITS-1:0] tv_mul;
  logic                  b_ws, b_nl, b_dig;

  always_comb begin
    logic [TOKEN_BITS-1:0] v;
    logic                  fin, raw_next;
    b_ws = is_ws(byte_in);
    b_nl = is_nl(byte_in);
    b_dig = is_digit(byte_in);
    tv_mul = TOKEN_BITS'(token_value * 10) + TOKEN_BITS'(byte_in - 8'h30);
    phase_next = phase; binary_next = binary_format; als_next = at_line_start;
    inc_next = cmt_active; bp_next = byte_phase; tv_next = token_value;
    tl_next = token_length; w_next = width_reg; h_next = height_reg;
    max_next = max_sample; hb_next = {8'd0, high_byte};
    ev_sample = 1'b0; ev_direct = 1'b0; sample_v = '0;
    d_kind = KIND_ERROR; d_err = ERR_MAGIC; d_last = 1'b0; fin = 1'b0;
    raw_next = 1'b0; v = token_value;
    unique case (phase)
      PH_MAG0: if (byte_in != 8'h50) begin
        ev_direct = 1'b1; d_err = ERR_MAGIC; phase_next = PH_ERROR;
      end else phase_next = PH_MAG1;
      PH_MAG1: begin
        if (byte_in == 8'h33) begin binary_next = 1'b0; phase_next = PH_MAG2; end
        else if (byte_in == 8'h36) begin binary_next = 1'b1; phase_next = PH_MAG2; end
        else begin ev_direct = 1'b1; d_err = ERR_MAGIC; phase_next = PH_ERROR; end
      end
      PH_MAG2: begin
        if (!b_ws) begin ev_direct = 1'b1; d_err = ERR_MAGIC; phase_next = PH_ERROR; end
        else begin als_next = b_nl; phase_next = PH_WIDTH; end
      end
      PH_RAW: begin
        if (max_sample > 16'd255) begin
          if (!byte_phase) begin hb_next = {8'd0, byte_in}; bp_next = 1'b1; end
          else begin bp_next = 1'b0; ev_sample = 1'b1; sample_v = {high_byte, byte_in}; end
        end else begin ev_sample = 1'b1; sample_v = {8'd0, byte_in}; end
      end
      PH_WIDTH, PH_HEIGHT, PH_MAXV, PH_TEXT: begin
        if (token_length != '0) begin
          if (b_dig) begin
            if (token_length >= LEN_LIMIT) begin
              ev_direct = 1'b1; d_err = ERR_LONG; phase_next = PH_ERROR;
            end else begin
              tl_next = token_length + 1'b1;
              tv_next = (tv_mul > TOKEN_SAT) ? TOKEN_SAT : tv_mul;
            end
          end else if (!b_ws) begin
            ev_direct = 1'b1; d_err = ERR_NONNUM; phase_next = PH_ERROR;
          end else begin
            fin = 1'b1;
            raw_next = (phase == PH_MAXV) && binary_format;
            if (!raw_next) als_next = b_nl;
          end
        end else if (cmt_active) begin
          if (b_nl) begin inc_next = 1'b0; als_next = 1'b1; end
        end else if (b_ws) als_next = b_nl;
        else if (byte_in == 8'h23 && at_line_start) inc_next = 1'b1;
        else if (b_dig) begin
          tl_next = LEN_BITS'(1); tv_next = TOKEN_BITS'(byte_in - 8'h30); als_next = 1'b0;
        end else begin ev_direct = 1'b1; d_err = ERR_NONNUM; phase_next = PH_ERROR; end
      end
      default: ;
    endcase
    // Token ended by whitespace, or by end of file.
    if (!fin && end_of_file && phase_next != PH_ERROR && tl_next != '0 &&
        (phase == PH_WIDTH || phase == PH_HEIGHT || phase == PH_MAXV || phase == PH_TEXT)) begin
      fin = 1'b1; v = tv_next;
    end
    if (fin) begin
      tv_next = '0; tl_next = '0;
      unique case (phase)
        PH_WIDTH: if (v > DIM_MAX) begin
          ev_direct = 1'b1; d_err = ERR_DIM; phase_next = PH_ERROR;
        end else begin w_next = DIM_BITS'(v); phase_next = PH_HEIGHT; end
        PH_HEIGHT: if (v > DIM_MAX) begin
          ev_direct = 1'b1; d_err = ERR_DIM; phase_next = PH_ERROR;
        end else begin h_next = DIM_BITS'(v); phase_next = PH_MAXV; end
        PH_MAXV: if (v == '0 || v > TOKEN_BITS'(65535)) begin
          ev_direct = 1'b1; d_err = ERR_MAXV; phase_next = PH_ERROR;
        end else begin
          max_next = v[15:0]; bp_next = 1'b0;
          ev_direct = 1'b1; d_kind = KIND_HEADER;
          d_last = (width_reg == '0) || (h_next == '0);
          phase_next = d_last ? PH_DONE : (binary_format ? PH_RAW : PH_TEXT);
        end
        default: begin
          ev_sample = 1'b1;
          sample_v = (v > TOKEN_BITS'(65535)) ? 16'hFFFF : v[15:0];
          if (v > TOKEN_BITS'(65535)) begin
            ev_sample = 1'b0; ev_direct = 1'b1; d_err = ERR_SAMPLE; phase_next = PH_ERROR;
          end
        end
      endcase
    end
    if (ev_sample && sample_v > max_sample) begin
      ev_sample = 1'b0; ev_direct = 1'b1; d_err = ERR_SAMPLE; phase_next = PH_ERROR;
    end
    // End of file not at the end of the image.
    ev_eof_pend = 1'b0;
    if (end_of_file && phase_next != PH_ERROR) begin
      if (ev_sample) ev_eof_pend = 1'b1;
      else if (phase_next != PH_DONE) begin
        ev_direct = 1'b1; d_kind = KIND_ERROR; d_err = ERR_EARLY; phase_next = PH_ERROR;
      end
    end
  end

  // Scaler: restoring division of sample*255 by the maximum, one bit a cycle.
  logic [23:0] dividend;
  logic [15:0] divisor;
  logic [16:0] rem;
  logic [4:0]  div_cnt;
  logic        div_busy, eof_pend;
  logic [16:0] rem_sh;
  logic [7:0]  scaled;

  assign rem_sh = {rem[15:0], dividend[23]};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      div_cnt <= '0;
    end else if (cmd.start) begin
      div_busy <= 1'b1;
      div_cnt <= 5'd24;
      dividend <= 24'(sample_v) * 24'd255;
      divisor <= max_sample;
      rem <= '0;
      eof_pend <= ev_eof_pend;
    end else if (div_busy) begin
      if (rem_sh >= {1'b0, divisor}) begin
        rem <= rem_sh - {1'b0, divisor};
        dividend <= {dividend[22:0], 1'b1};
      end else begin
        rem <= rem_sh;
        dividend <= {dividend[22:0], 1'b0};
      end
      div_cnt <= div_cnt - 1'b1;
      if (div_cnt == 5'd1) div_busy <= 1'b0;
    end
  end

  assign scaled = dividend[7:0];
  assign stat.need_div = ev_sample;
  assign stat.direct = ev_direct;
  assign stat.div_done = !div_busy;
  assign stat.out_full = out_valid;

  logic pix_last;
  assign pix_last = (column_count + 1'b1 == width_reg) && (row_count + 1'b1 == height_reg);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_MAG0; binary_format <= 1'b0; token_value <= '0; token_length <= '0;
      at_line_start <= 1'b0; cmt_active <= 1'b0; width_reg <= '0; height_reg <= '0;
      max_sample <= '0; column_count <= '0; row_count <= '0; channel_index <= '0;
      held_red <= '0; held_green <= '0; high_byte <= '0; byte_phase <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (accept && phase != PH_DONE && phase != PH_ERROR) begin
        phase <= phase_next; binary_format <= binary_next; token_value <= tv_next;
        token_length <= tl_next; at_line_start <= als_next; cmt_active <= inc_next;
        width_reg <= w_next; height_reg <= h_next; max_sample <= max_next;
        high_byte <= hb_next[7:0]; byte_phase <= bp_next;
        if (ev_direct && d_kind == KIND_HEADER) begin
          column_count <= '0; row_count <= '0; channel_index <= '0;
        end
        if (ev_direct) begin
          out_valid <= 1'b1; kind <= d_kind; red <= '0; green <= '0; blue <= '0;
          is_binary <= (d_kind == KIND_HEADER) ? binary_format : 1'b0;
          image_width <= (d_kind == KIND_HEADER) ? 16'(width_reg) : '0;
          image_height <= (d_kind == KIND_HEADER) ? 16'(h_next) : '0;
          error_code <= (d_kind == KIND_ERROR) ? d_err : ERR_MAGIC;
          last_pixel <= d_last && (d_kind == KIND_HEADER);
        end
      end
      if (cmd.emit) begin
        unique case (channel_index)
          2'd0: begin held_red <= scaled; channel_index <= 2'd1; end
          2'd1: begin held_green <= scaled; channel_index <= 2'd2; end
          default: begin
            channel_index <= 2'd0;
            if (column_count + 1'b1 >= width_reg) begin
              column_count <= '0; row_count <= row_count + 1'b1;
            end else column_count <= column_count + 1'b1;
            if (pix_last) phase <= PH_DONE;
          end
        endcase
        if (channel_index == 2'd2 || eof_pend) begin
          out_valid <= 1'b1;
          red <= '0; green <= '0; blue <= '0; image_width <= '0; image_height <= '0;
          is_binary <= 1'b0; error_code <= ERR_MAGIC; last_pixel <= 1'b0;
          if (eof_pend && !(channel_index == 2'd2 && pix_last)) begin
            kind <= KIND_ERROR; error_code <= ERR_EARLY; phase <= PH_ERROR;
          end else begin
            kind <= KIND_PIXEL; red <= held_red; green <= held_green; blue <= scaled;
            last_pixel <= pix_last;
          end
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_one_source: assert property (@(posedge clk) disable iff (rst)
    !(accept && ev_direct && cmd.start)) else $error("two result sources");
  a_div_len: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> div_busy) else $error("scaler idle after start");
  a_done_quiet: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DONE || phase == PH_ERROR) && !out_valid |=> !out_valid)
    else $error("result after end");
`endif
endmodule

FILE: sv/ppm_stream_parser.sv
// Top level: PPM P3/P6 stream parser.
//  channel | dir | payload
//  in      | in  | byte_in[8], end_of_file[1]
//  out     | out | kind, red, green, blue, image_width, image_height, is_binary,
//          |     | error_code, last_pixel
// A byte that gives no result leaves the parser ready for the next one; one that gives a
// header or error result holds off the next byte until the result register drains.
// A byte that completes a sample waits for the 24-step restoring divider of the
// scaler and for a free result register; one that completes a pixel loads it.
// One result register; a new byte waits while it holds an untaken result.
// Synchronous reset returns the parser to the magic check.
module ppm_stream_parser #(
  parameter int MAX_TOKEN_LEN = 1024,
  parameter int DIM_BITS      = 16
) (
  input logic     clk,
  input logic     rst,
  pps_in_if.sink  in_ch,
  pps_out_if.source out_ch
);
  import pps_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     accept;

  pps_ctrl u_ctrl (
    .clk, .rst, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .stat, .cmd, .accept
  );

  pps_datapath #(.MAX_TOKEN_LEN(MAX_TOKEN_LEN), .DIM_BITS(DIM_BITS)) u_dp (
    .clk, .rst, .accept, .byte_in(in_ch.byte_in), .end_of_file(in_ch.end_of_file),
    .cmd, .stat, .out_ready(out_ch.ready), .out_valid(out_ch.valid),
    .kind(out_ch.kind), .red(out_ch.red), .green(out_ch.green), .blue(out_ch.blue),
    .image_width(out_ch.image_width), .image_height(out_ch.image_height),
    .is_binary(out_ch.is_binary), .error_code(out_ch.error_code),
    .last_pixel(out_ch.last_pixel)
  );
endmodule

FILE: sim/ppm_stream_parser_test.sv
// Testbench: one random PPM file through the parser, results checked against a local predictor.
module ppm_stream_parser_test;
  import pps_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic        is_binary;
    logic [2:0]  error_code;
    logic        last_pixel;
  } pixel_result_t;

  typedef struct packed {
    logic [7:0] data;
    logic       eof;
  } file_byte_t;

  localparam int STALL_LIMIT = 5000;
  localparam int QUIET_TAIL  = 150;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pps_in_if  in_ch();
  pps_out_if out_ch();

  ppm_stream_parser dut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  file_byte_t    file_bytes[$];
  pixel_result_t expected_results[$];
  int            fail_count;
  int            bytes_accepted;
  int            results_taken;

  // Parser state as predicted
  phase_t      stage;
  bit          is_p6, line_start, in_cmt, hi_pending;
  int unsigned tok_val, tok_len, wid, hgt, maxv, col, row, chan;
  logic [7:0]  red_h, grn_h, hi_byte;
  bit            got;
  pixel_result_t pend;

  function automatic bit white(input logic [7:0] b);
    return b == " " || b == 8'h09 || b == 8'h0D || b == 8'h0A;
  endfunction

  function automatic bit eol(input logic [7:0] b);
    return b == 8'h0D || b == 8'h0A;
  endfunction

  function automatic void post(input logic [1:0] k, input logic [7:0] r, input logic [7:0] g,
                               input logic [7:0] bl, input logic [15:0] w, input logic [15:0] h,
                               input logic bin, input logic [2:0] e, input logic last);
    got = 1;
    pend = '{kind: k, red: r, green: g, blue: bl, image_width: w, image_height: h,
             is_binary: bin, error_code: e, last_pixel: last};
  endfunction

  function automatic void raise_error(input logic [2:0] code);
    stage = PH_ERROR;
    post(KIND_ERROR, 0, 0, 0, 0, 0, 0, code, 0);
  endfunction

  function automatic void scale_sample(input int unsigned v);
    int unsigned scaled;
    bit last;
    if (v > maxv || maxv == 0) begin
      raise_error(ERR_SAMPLE);
      return;
    end
    scaled = (v * 255) / maxv;
    if (chan == 0) begin
      red_h = scaled[7:0];
      chan = 1;
      return;
    end
    if (chan == 1) begin
      grn_h = scaled[7:0];
      chan = 2;
      return;
    end
    chan = 0;
    last = (col + 1 == wid) && (row + 1 == hgt);
    post(KIND_PIXEL, red_h, grn_h, scaled[7:0], 0, 0, 0, 0, last);
    col++;
    if (col >= wid) begin
      col = 0;
      row++;
    end
    if (last) stage = PH_DONE;
  endfunction

  function automatic void close_token();
    int unsigned v;
    bit empty;
    v = tok_val;
    tok_val = 0;
    tok_len = 0;
    case (stage)
      PH_WIDTH: begin
        if (v > 65535) raise_error(ERR_DIM);
        else begin
          wid = v;
          stage = PH_HEIGHT;
        end
      end
      PH_HEIGHT: begin
        if (v > 65535) raise_error(ERR_DIM);
        else begin
          hgt = v;
          stage = PH_MAXV;
        end
      end
      PH_MAXV: begin
        if (v == 0 || v > 65535) raise_error(ERR_MAXV);
        else begin
          maxv = v;
          empty = (wid == 0) || (hgt == 0);
          col = 0;
          row = 0;
          chan = 0;
          hi_pending = 0;
          post(KIND_HEADER, 0, 0, 0, wid[15:0], hgt[15:0], is_p6, 0, empty);
          stage = empty ? PH_DONE : (is_p6 ? PH_RAW : PH_TEXT);
        end
      end
      default: scale_sample(v);
    endcase
  endfunction

  function automatic void scan_byte(input logic [7:0] b);
    bit raw_next;
    case (stage)
      PH_MAG0: begin
        if (b != "P") raise_error(ERR_MAGIC);
        else stage = PH_MAG1;
        return;
      end
      PH_MAG1: begin
        if (b == "3") is_p6 = 0;
        else if (b == "6") is_p6 = 1;
        else begin
          raise_error(ERR_MAGIC);
          return;
        end
        stage = PH_MAG2;
        return;
      end
      PH_MAG2: begin
        if (!white(b)) begin
          raise_error(ERR_MAGIC);
          return;
        end
        line_start = eol(b);
        stage = PH_WIDTH;
        return;
      end
      PH_RAW: begin
        if (maxv > 255) begin
          if (!hi_pending) begin
            hi_byte = b;
            hi_pending = 1;
            return;
          end
          hi_pending = 0;
          scale_sample({hi_byte, b});
          return;
        end
        scale_sample(b);
        return;
      end
      PH_WIDTH, PH_HEIGHT, PH_MAXV, PH_TEXT: ;
      default: return;
    endcase
    if (tok_len > 0) begin
      if (b >= "0" && b <= "9") begin
        if (tok_len >= 1023) begin
          raise_error(ERR_LONG);
          return;
        end
        tok_len++;
        tok_val = tok_val * 10 + (b - "0");
        if (tok_val > 65536) tok_val = 65536;
        return;
      end
      if (!white(b)) begin
        raise_error(ERR_NONNUM);
        return;
      end
      raw_next = (stage == PH_MAXV) && is_p6;
      close_token();
      if (stage != PH_ERROR && !raw_next) line_start = eol(b);
      return;
    end
    if (in_cmt) begin
      if (eol(b)) begin
        in_cmt = 0;
        line_start = 1;
      end
      return;
    end
    if (white(b)) begin
      line_start = eol(b);
      return;
    end
    if (b == "#" && line_start) begin
      in_cmt = 1;
      return;
    end
    if (b >= "0" && b <= "9") begin
      tok_len = 1;
      tok_val = b - "0";
      line_start = 0;
      return;
    end
    raise_error(ERR_NONNUM);
  endfunction

  function automatic void parse_byte(input logic [7:0] b, input logic eof);
    got = 0;
    if (stage == PH_DONE || stage == PH_ERROR) return;
    scan_byte(b);
    if (stage != PH_ERROR && eof) begin
      if (tok_len > 0 && stage inside {PH_WIDTH, PH_HEIGHT, PH_MAXV, PH_TEXT}) close_token();
      if (stage != PH_ERROR && stage != PH_DONE) raise_error(ERR_EARLY);
    end
    if (got) expected_results.push_back(pend);
  endfunction

  // File generation
  function automatic void put_byte(input logic [7:0] b);
    file_bytes.push_back('{data: b, eof: 1'b0});
  endfunction

  function automatic void put_number(input int unsigned v);
    string s;
    if ($urandom_range(0, 15) == 0) s = "00";
    s = {s, $sformatf("%0d", v)};
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endfunction

  function automatic void put_space(input bit allow_comment);
    logic [7:0] ws[4];
    ws = '{" ", 8'h09, 8'h0D, 8'h0A};
    repeat ($urandom_range(1, 3)) put_byte(ws[$urandom_range(0, 3)]);
    if (allow_comment && $urandom_range(0, 7) == 0) begin
      put_byte(8'h0A);
      put_byte("#");
      repeat ($urandom_range(0, 12)) begin
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        put_byte(eol(c) ? 8'hFF : c);
      end
      put_byte($urandom_range(0, 1) ? 8'h0A : 8'h0D);
    end
  endfunction

  function automatic void build_file();
    int ending, w, h, npix, mx, nsamp, cut;
    bit p6, wide;
    ending = $urandom_range(0, 11);
    p6 = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 4))
      0: mx = 255;
      1: mx = 65535;
      2: mx = $urandom_range(1, 254);
      3: mx = $urandom_range(256, 1000);
      default: mx = $urandom_range(1, 65535);
    endcase
    wide = mx > 255;
    npix = !p6 ? 80 : (wide ? 230 : 450);
    w = $urandom_range(1, 40);
    h = npix / w;
    if (h < 1) h = 1;
    if (ending == 6) begin
      case ($urandom_range(0, 2))
        0: put_byte($urandom_range(0, 1) ? 8'(8'h50 ^ (1 << $urandom_range(0, 7))) : "p");
        1: begin
          put_byte("P");
          put_byte("5");
        end
        default: begin
          put_byte("P");
          put_byte("3");
          put_byte("x");
        end
      endcase
    end
    put_byte("P");
    put_byte(p6 ? "6" : "3");
    put_space(1);
    if (ending == 9) begin
      case ($urandom_range(0, 3))
        0: mx = 0;
        1: mx = 65536 + $urandom_range(0, 99999);
        2: w = 65536;
        default: h = 0;
      endcase
    end
    if (ending == 10) put_byte("-");
    put_number(w);
    put_space(1);
    put_number(h);
    put_space(1);
    put_number(mx);
    if (p6) put_byte($urandom_range(0, 1) ? " " : 8'h0A);
    else put_space(1);
    nsamp = 3 * w * h;
    if (nsamp > 3 * npix + 30) nsamp = 3 * npix + 30;
    cut = $urandom_range(1, nsamp - 1);
    for (int i = 0; i < nsamp; i++) begin
      int unsigned v;
      if (i == cut && ending == 5) break;
      case ($urandom_range(0, 7))
        0: v = 0;
        1: v = mx;
        default: v = $urandom_range(0, mx);
      endcase
      if (i == cut && ending == 7) v = mx + 1;
      if (i == cut && ending == 11 && !p6) begin
        put_byte($urandom_range(0, 1) ? "#" : "+");
        break;
      end
      if (i == cut && ending == 8 && !p6) begin
        repeat (1030) put_byte($urandom_range(0, 1) ? "0" : "9");
        break;
      end
      if (p6) begin
        if (wide) put_byte(v[15:8]);
        put_byte(v[7:0]);
      end else begin
        put_number(v);
        if (i != nsamp - 1 || $urandom_range(0, 1)) put_space(1);
      end
    end
    file_bytes[file_bytes.size() - 1].eof = 1'b1;
    repeat (24) file_bytes.push_back('{data: 8'($urandom_range(0, 255)),
                                       eof: 1'($urandom_range(0, 1))});
  endfunction

  // Driver
  int         next_idx;
  int         send_gap;
  int         drain_at;
  bit         drained;
  logic [7:0] cur_data;
  logic       cur_eof;

  always @(posedge clk) begin
    bit offer;
    bit late;
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.byte_in <= 8'd0;
      in_ch.end_of_file <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        parse_byte(cur_data, cur_eof);
        bytes_accepted++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        offer = 0;
        late = next_idx + QUIET_TAIL > file_bytes.size();
        if (next_idx == drain_at && !drained) begin
          if (expected_results.size() == 0) drained = 1;
        end else if (send_gap > 0) begin
          send_gap--;
        end else if (!late && $urandom_range(0, 11) == 0) begin
          send_gap = $urandom_range(0, 16);
        end else if (next_idx < file_bytes.size()) begin
          offer = 1;
        end
        in_ch.valid <= offer;
        if (offer) begin
          cur_data = file_bytes[next_idx].data;
          cur_eof = file_bytes[next_idx].eof;
          in_ch.byte_in <= cur_data;
          in_ch.end_of_file <= cur_eof;
          next_idx++;
        end
      end
    end
  end

  // Monitor
  int  hold_cycles;
  bit  held_once;

  task automatic check_field(input string name, input int unsigned want, input int unsigned seen);
    if (want != seen) begin
      $error("%s: expected %0d, got %0d", name, want, seen);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    pixel_result_t want;
    bit rdy;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_taken++;
        if (expected_results.size() == 0) begin
          $error("result with no expectation: kind %0d", out_ch.kind);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("kind", want.kind, out_ch.kind);
          check_field("red", want.red, out_ch.red);
          check_field("green", want.green, out_ch.green);
          check_field("blue", want.blue, out_ch.blue);
          check_field("image_width", want.image_width, out_ch.image_width);
          check_field("image_height", want.image_height, out_ch.image_height);
          check_field("is_binary", want.is_binary, out_ch.is_binary);
          check_field("error_code", want.error_code, out_ch.error_code);
          check_field("last_pixel", want.last_pixel, out_ch.last_pixel);
        end
      end
      rdy = 1;
      if (!held_once && bytes_accepted >= 1) begin
        held_once = 1;
        hold_cycles = 400;
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        rdy = 0;
      end else if (next_idx + QUIET_TAIL <= file_bytes.size()
                   && $urandom_range(0, 11) == 0) begin
        hold_cycles = $urandom_range(0, 16);
        rdy = 0;
      end
      out_ch.ready <= rdy;
    end
  end

  // Watchdog
  int quiet_cycles;

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.byte_in = 8'd0;
    in_ch.end_of_file = 1'b0;
    out_ch.ready = 1'b0;
    stage = PH_MAG0;
    build_file();
    drain_at = file_bytes.size() / 2;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    while (bytes_accepted < file_bytes.size() || expected_results.size() != 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
